@@ rtl/fir_filter_with_center_tap_top_defines.svh @@
// Assertion macros shared by the FIR filter checker.
// No dependencies; every macro expects clk and rst_n in scope.
`ifndef FIR_FILTER_WITH_CENTER_TAP_TOP_DEFINES_SVH
`define FIR_FILTER_WITH_CENTER_TAP_TOP_DEFINES_SVH

// valid must stay up until the transfer happens
`define FWC_HOLD(lbl, vld, rdy) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  ((vld) && !(rdy)) |=> (vld)) else $error("valid dropped before transfer");

// payload must not move while a transfer is stalled
`define FWC_STABLE(lbl, vld, rdy, sig) lbl: assert property (@(posedge clk) \
  disable iff (!rst_n) ((vld) && !(rdy)) |=> $stable(sig)) \
  else $error("payload changed while stalled");

// condition that holds at every edge out of reset
`define FWC_ALWAYS(lbl, cond) lbl: assert property (@(posedge clk) disable iff (!rst_n) \
  (cond)) else $error("invariant broken");

`endif

@@ rtl/fwc_pkg.sv @@
// Shared types and constants for the FIR filter with center tap.
// No dependencies.
package fwc_pkg;

  localparam int VALUE_W  = 16;
  localparam int ACC_W    = 32;
  localparam int IDX_W    = 6;
  localparam int TAPCFG_W = 7;

  localparam logic [TAPCFG_W-1:0] TAP_COUNT_RST = 7'd64;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_COEF = 1'b1
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [IDX_W-1:0]   coeff_index;
    logic [VALUE_W-1:0] value;
  } item_t;

  // head of the queue between front and back
  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

endpackage

@@ rtl/fwc_front.sv @@
// Front end: input handshake and a two-entry queue of items.
// Depends on fwc_pkg.
module fwc_front
  import fwc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [IDX_W-1:0]   in_coeff_index,
  input  logic [VALUE_W-1:0] in_value,
  output qhead_t             head,
  input  logic               pop
);

  item_t      q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop_ok;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign pop_ok   = pop && (cnt_r != 2'd0);

  assign head.valid = (cnt_r != 2'd0);
  assign head.item  = q_r[rp_r];

  // pointer and fill bookkeeping
  always_comb begin
    wp_nxt  = push   ? ~wp_r : wp_r;
    rp_nxt  = pop_ok ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    case ({push, pop_ok})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{op: op_t'(in_op), coeff_index: in_coeff_index, value: in_value};
    end
  end

endmodule

@@ rtl/fwc_back.sv @@
// Back end: delay line and coefficient memories, one shared MAC walking
// the taps, center-tap capture and the output register. Depends on fwc_pkg.
module fwc_back
  import fwc_pkg::*;
#(
  parameter int MAX_TAPS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  qhead_t                    head,
  output logic                      pop,
  input  logic [TAPCFG_W-1:0]       tap_count,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [ACC_W-1:0]   out_filtered,
  output logic signed [VALUE_W-1:0] out_delayed_sample
);

  localparam int AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_TAPS - 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ISSUE = 4'b0010,
    S_DRAIN = 4'b0100,
    S_OUT   = 4'b1000
  } seq_state_t;

  seq_state_t state_r, state_nxt;

  logic [VALUE_W-1:0] dl_mem [MAX_TAPS];
  logic [VALUE_W-1:0] cf_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0] dl_vld_r;

  logic [AW-1:0] pos_r, slot_r, k_r, taps_m1_r, ctr_idx_r;
  logic [AW-1:0] new_pos, taps_m1;
  logic          dl_we, cf_we, issue, load_out;
  logic          r_vld_r, r_last_r, r_ctr_r;
  logic          p_vld_r, p_last_r;
  logic          out_valid_r;

  logic [VALUE_W-1:0] dl_rd_r, cf_rd_r, center_r;
  logic               rv_r;
  logic [ACC_W-1:0]   prod_r, acc_r;
  logic [ACC_W-1:0]   out_filtered_r;
  logic [VALUE_W-1:0] out_delayed_r;

  // item decode
  assign pop     = (state_r == S_IDLE) && head.valid;
  assign dl_we   = pop && (head.item.op == OP_PUSH);
  assign cf_we   = pop && (head.item.op == OP_COEF) && (32'(head.item.coeff_index) < MAX_TAPS);
  assign new_pos = (pos_r == '0) ? LAST_SLOT : pos_r - AW'(1);
  assign issue   = (state_r == S_ISSUE);
  assign load_out = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // active taps minus one: zero means one tap, saturate at the line length
  always_comb begin
    if (tap_count == '0) begin
      taps_m1 = '0;
    end else if (32'(tap_count) >= MAX_TAPS) begin
      taps_m1 = LAST_SLOT;
    end else begin
      taps_m1 = AW'(tap_count - TAPCFG_W'(1));
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (dl_we) state_nxt = S_ISSUE;
      S_ISSUE: if (k_r == taps_m1_r) state_nxt = S_DRAIN;
      S_DRAIN: if (p_vld_r && p_last_r) state_nxt = S_OUT;
      S_OUT:   if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      slot_r      <= '0;
      k_r         <= '0;
      taps_m1_r   <= '0;
      ctr_idx_r   <= '0;
      r_vld_r     <= 1'b0;
      r_last_r    <= 1'b0;
      r_ctr_r     <= 1'b0;
      p_vld_r     <= 1'b0;
      p_last_r    <= 1'b0;
      out_valid_r <= 1'b0;
      dl_vld_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (dl_we) begin
        pos_r            <= new_pos;
        slot_r           <= new_pos;
        k_r              <= '0;
        taps_m1_r        <= taps_m1;
        ctr_idx_r        <= taps_m1 >> 1;
        dl_vld_r[new_pos] <= 1'b1;
      end else if (issue) begin
        k_r    <= k_r + AW'(1);
        slot_r <= (slot_r == LAST_SLOT) ? '0 : slot_r + AW'(1);
      end
      // read stage, then product stage
      r_vld_r  <= issue;
      r_last_r <= issue && (k_r == taps_m1_r);
      r_ctr_r  <= issue && (k_r == ctr_idx_r);
      p_vld_r  <= r_vld_r;
      p_last_r <= r_last_r;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // memories: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (dl_we) begin
      dl_mem[new_pos] <= head.item.value;
    end
    if (cf_we) begin
      cf_mem[AW'(head.item.coeff_index)] <= head.item.value;
    end
    dl_rd_r <= dl_mem[slot_r];
    cf_rd_r <= cf_mem[k_r];
    rv_r    <= dl_vld_r[slot_r];
  end

  // MAC datapath and output register
  always_ff @(posedge clk) begin
    prod_r <= ACC_W'($signed(cf_rd_r)) * ACC_W'($signed(rv_r ? dl_rd_r : VALUE_W'(0)));
    if (r_vld_r && r_ctr_r) begin
      center_r <= rv_r ? dl_rd_r : VALUE_W'(0);
    end
    if (dl_we) begin
      acc_r <= '0;
    end else if (p_vld_r) begin
      acc_r <= acc_r + prod_r;
    end
    if (load_out) begin
      out_filtered_r <= acc_r;
      out_delayed_r  <= center_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered       = out_filtered_r;
  assign out_delayed_sample = out_delayed_r;

endmodule

@@ rtl/fir_filter_with_center_tap_top.sv @@
// Top level of the streaming FIR filter with center-tap output.
// Holds the tap-count register; depends on fwc_pkg, fwc_front, fwc_back.
//
// A sample transfer yields one result: the wrapping 32-bit sum of coeff[k]
// times x[n-k] over the active taps, and the sample delayed by
// (taps-1)/2. A coefficient write yields no result. The number of taps
// runs from 1 to MAX_TAPS, and the single shared multiply-accumulate unit
// reads one tap per cycle from the delay-line and coefficient memories.
// A two-entry queue keeps accepting items while a sample is in work or a
// result waits, until the queue is full.
// The tap-count register resets to 64; zero acts as one tap and values
// above MAX_TAPS act as MAX_TAPS. Coefficients must be written before use.
module fir_filter_with_center_tap_top
  import fwc_pkg::*;
#(
  parameter int MAX_TAPS = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_op,
  input  logic [IDX_W-1:0]          in_coeff_index,
  input  logic signed [VALUE_W-1:0] in_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [ACC_W-1:0]   out_filtered,
  output logic signed [VALUE_W-1:0] out_delayed_sample,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [TAPCFG_W-1:0]       cfg_tap_count
);

  logic [TAPCFG_W-1:0] tap_count_r;
  qhead_t              head;
  logic                pop;

  // configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      tap_count_r <= cfg_tap_count;
    end
  end

  fwc_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_coeff_index (in_coeff_index),
    .in_value       (in_value),
    .head           (head),
    .pop            (pop)
  );

  fwc_back #(
    .MAX_TAPS (MAX_TAPS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .pop                (pop),
    .tap_count          (tap_count_r),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_filtered       (out_filtered),
    .out_delayed_sample (out_delayed_sample)
  );

endmodule

@@ rtl/fwc_checker.sv @@
// Port-level checker for the FIR filter, bound to the top level.
// Depends on fwc_pkg and fir_filter_with_center_tap_top_defines.svh.
`include "fir_filter_with_center_tap_top_defines.svh"

module fwc_checker
  import fwc_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_op,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [ACC_W-1:0]   out_filtered,
  input logic signed [VALUE_W-1:0] out_delayed_sample
);

  logic [3:0] pending_r, pending_nxt;
  logic       smp_in, res_out;

  // samples accepted but whose result has not been transferred yet
  assign smp_in  = in_valid && in_ready && (op_t'(in_op) == OP_PUSH);
  assign res_out = out_valid && out_ready;

  always_comb begin
    pending_nxt = pending_r;
    case ({smp_in, res_out})
      2'b10:   pending_nxt = pending_r + 4'd1;
      2'b01:   pending_nxt = pending_r - 4'd1;
      default: pending_nxt = pending_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 4'd0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  `FWC_HOLD(a_out_hold, out_valid, out_ready)
  `FWC_STABLE(a_out_stable, out_valid, out_ready, ({out_filtered, out_delayed_sample}))
  `FWC_ALWAYS(a_no_spurious, (!out_valid || (pending_r != 4'd0)))
  `FWC_ALWAYS(a_pending_bound, (pending_r <= 4'd4))

endmodule

bind fir_filter_with_center_tap_top fwc_checker u_fwc_checker (.*);
